@@ hdl/adcl_pkg.sv @@
// ----------------------------------------------------------------------------
// Airtime duty-cycle limiter package
// Shared widths, request and register codes, window constants and the
// control bundle that the sequencer hands to the datapath.
// ----------------------------------------------------------------------------
package adcl_pkg;

    // Field widths.
    localparam int TIME_W = 48;
    localparam int DUR_W  = 22;
    localparam int CPCT_W = 14;
    localparam int ENTRY_W = TIME_W + DUR_W;

    // Window sums stay below 128 entries times one hour in milliseconds.
    localparam int SUM_W = 29;

    // Reciprocal multiplier operand and product widths.
    localparam int MUL_W  = 20;
    localparam int PROD_W = 2 * MUL_W;

    // Request codes.
    localparam logic REQ_RECORD = 1'b0;
    localparam logic REQ_QUERY  = 1'b1;

    // Configuration register indexes.
    localparam int  CFG_ADDR_W = 1;
    localparam logic [CFG_ADDR_W-1:0] CFG_SHORT_LIMIT = 1'b0;
    localparam logic [CFG_ADDR_W-1:0] CFG_LONG_LIMIT  = 1'b1;

    // Durations saturate at one hour.
    localparam logic [DUR_W-1:0] MAX_DUR_MS = 22'd3600000;

    // Window lengths in microseconds, used for the cutoff times.
    localparam logic [TIME_W-1:0] SHORT_WIN_US = 48'd60000000;
    localparam logic [TIME_W-1:0] LONG_WIN_US  = 48'd3600000000;

    // Window lengths in milliseconds: a sum at or above these caps at full scale.
    localparam logic [SUM_W-1:0] SHORT_WIN_MS = 29'd60000;
    localparam logic [SUM_W-1:0] LONG_WIN_MS  = 29'd3600000;
    localparam logic [CPCT_W-1:0] FULL_CPCT   = 14'd10000;

    // Short: sum * 10000 / 60000 = sum / 6, via (sum * 43691) >> 18.
    // Long: sum * 10000 / 3600000 = (sum >> 3) / 45, via (y * 745655) >> 25.
    localparam logic [MUL_W-1:0] SHORT_RECIP = 20'd43691;
    localparam logic [MUL_W-1:0] LONG_RECIP  = 20'd745655;
    localparam int SHORT_SHIFT = 18;
    localparam int LONG_SHIFT  = 25;

    // Sequencer states.
    typedef enum logic [4:0] {
        ST_IDLE  = 5'b00001,
        ST_WALK  = 5'b00010,
        ST_MUL_S = 5'b00100,
        ST_MUL_L = 5'b01000,
        ST_FIN   = 5'b10000
    } adcl_state_t;

    // Control bundle from the sequencer to the datapath.
    typedef struct packed {
        logic start;      // query beat accepted: load cutoffs, clear sums
        logic entry_vld;  // ring read data is valid this cycle
        logic mul_short;  // run the multiplier on the short-window sum
        logic mul_long;   // run the multiplier on the long-window sum
    } adcl_ctl_t;

endpackage

@@ hdl/adcl_ram.sv @@
// ----------------------------------------------------------------------------
// Generic simple dual-port RAM
// One write port and one read port, read data registered.
// ----------------------------------------------------------------------------
module adcl_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16,
    localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic              aclk,
    input  logic              wr_en,
    input  logic [ADDR_W-1:0] wr_addr,
    input  logic [WIDTH-1:0]  wr_data,
    input  logic              rd_en,
    input  logic [ADDR_W-1:0] rd_addr,
    output logic [WIDTH-1:0]  rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    // Write port.
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
    end

    // Registered read port.
    always_ff @(posedge aclk) begin
        if (rd_en) begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

@@ hdl/adcl_seq.sv @@
// ----------------------------------------------------------------------------
// Duty-cycle limiter sequencer
// Owns the ring head and fill count, issues the newest-to-oldest ring walk
// and steps the datapath through the walk, both divisions and the result.
// ----------------------------------------------------------------------------
module adcl_seq #(
    parameter int SLOTS = 64,
    localparam int IDX_W = (SLOTS > 1) ? $clog2(SLOTS) : 1,
    localparam int CNT_W = $clog2(SLOTS + 1)
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_valid,
    input  logic                 s_req_type,
    output logic                 s_ready,
    input  logic                 out_free,
    input  logic                 long_act,
    output adcl_pkg::adcl_ctl_t  ctl,
    output logic                 wr_en,
    output logic [IDX_W-1:0]     wr_addr,
    output logic                 rd_en,
    output logic [IDX_W-1:0]     rd_addr,
    output logic                 out_load
);

    import adcl_pkg::*;

    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(SLOTS - 1);
    localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(SLOTS);

    adcl_state_t      state_reg, state_next;
    logic [IDX_W-1:0] head_reg, head_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic [IDX_W-1:0] addr_reg, addr_next;
    logic [CNT_W-1:0] left_reg, left_next;
    logic             pend_reg, pend_next;
    logic             accept;
    logic             issue;
    logic [IDX_W-1:0] head_prev;
    logic [IDX_W-1:0] addr_prev;

    assign accept    = s_valid && s_ready;
    assign head_prev = (head_reg == '0) ? LAST_IDX : head_reg - 1'b1;
    assign addr_prev = (addr_reg == '0) ? LAST_IDX : addr_reg - 1'b1;

    // A new ring read goes out while entries remain and the long window is open.
    assign issue = (state_reg == ST_WALK) && (left_reg != '0) && long_act;

    assign s_ready = (state_reg == ST_IDLE);
    assign wr_en   = accept && (s_req_type == REQ_RECORD);
    assign wr_addr = head_reg;
    assign rd_en   = issue;
    assign rd_addr = addr_reg;

    assign ctl.start     = accept && (s_req_type == REQ_QUERY);
    assign ctl.entry_vld = pend_reg;
    assign ctl.mul_short = (state_reg == ST_MUL_S);
    assign ctl.mul_long  = (state_reg == ST_MUL_L);
    assign out_load      = (state_reg == ST_FIN) && out_free;

    // Next-state and bookkeeping logic.
    always_comb begin
        state_next = state_reg;
        head_next  = head_reg;
        count_next = count_reg;
        addr_next  = addr_reg;
        left_next  = left_reg;
        pend_next  = issue;
        case (state_reg)
            ST_IDLE: begin
                if (accept) begin
                    if (s_req_type == REQ_RECORD) begin
                        head_next = (head_reg == LAST_IDX) ? '0 : head_reg + 1'b1;
                        if (count_reg != FULL_CNT) begin
                            count_next = count_reg + 1'b1;
                        end
                    end else begin
                        addr_next  = head_prev;
                        left_next  = count_reg;
                        state_next = ST_WALK;
                    end
                end
            end
            ST_WALK: begin
                if (issue) begin
                    addr_next = addr_prev;
                    left_next = left_reg - 1'b1;
                end
                // Done once nothing is in flight and nothing more is issued.
                if (!pend_reg && !issue) begin
                    state_next = ST_MUL_S;
                end
            end
            ST_MUL_S: begin
                state_next = ST_MUL_L;
            end
            ST_MUL_L: begin
                state_next = ST_FIN;
            end
            ST_FIN: begin
                if (out_free) begin
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // State registers.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            head_reg  <= '0;
            count_reg <= '0;
            pend_reg  <= 1'b0;
        end else begin
            state_reg <= state_next;
            head_reg  <= head_next;
            count_reg <= count_next;
            pend_reg  <= pend_next;
        end
    end

    // Walk address and remaining entries.
    always_ff @(posedge aclk) begin
        addr_reg <= addr_next;
        left_reg <= left_next;
    end

endmodule

@@ hdl/adcl_datapath.sv @@
// ----------------------------------------------------------------------------
// Duty-cycle limiter datapath
// Window cutoffs, the two running sums of the ring walk and one shared
// reciprocal multiplier that turns both sums into hundredths of a percent.
// ----------------------------------------------------------------------------
module adcl_datapath (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  adcl_pkg::adcl_ctl_t           ctl,
    input  logic [adcl_pkg::TIME_W-1:0]   now_us,
    input  logic [adcl_pkg::TIME_W-1:0]   ent_time,
    input  logic [adcl_pkg::DUR_W-1:0]    ent_dur,
    output logic                          long_act,
    output logic [adcl_pkg::CPCT_W-1:0]   short_cpct,
    output logic [adcl_pkg::CPCT_W-1:0]   long_cpct
);

    import adcl_pkg::*;

    logic [TIME_W-1:0] short_cut_reg;
    logic [TIME_W-1:0] long_cut_reg;
    logic              short_act_reg;
    logic              long_act_reg;
    logic [SUM_W-1:0]  short_sum_reg;
    logic [SUM_W-1:0]  long_sum_reg;
    logic [PROD_W-1:0] prod_reg;
    logic [CPCT_W-1:0] short_cpct_reg;
    logic [TIME_W-1:0] short_cut;
    logic [TIME_W-1:0] long_cut;
    logic [SUM_W-1:0]  dur_ext;
    logic [MUL_W-1:0]  mul_a;
    logic [MUL_W-1:0]  mul_b;

    // Cutoff times clamp at zero early after start.
    assign short_cut = (now_us < SHORT_WIN_US) ? '0 : now_us - SHORT_WIN_US;
    assign long_cut  = (now_us < LONG_WIN_US)  ? '0 : now_us - LONG_WIN_US;
    assign dur_ext   = SUM_W'(ent_dur);

    always_ff @(posedge aclk) begin
        if (ctl.start) begin
            short_cut_reg <= short_cut;
            long_cut_reg  <= long_cut;
        end
    end

    // Window flags: a window closes at its first entry older than its cutoff.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            short_act_reg <= 1'b0;
            long_act_reg  <= 1'b0;
        end else if (ctl.start) begin
            short_act_reg <= 1'b1;
            long_act_reg  <= 1'b1;
        end else if (ctl.entry_vld) begin
            if (ent_time < short_cut_reg) begin
                short_act_reg <= 1'b0;
            end
            if (ent_time < long_cut_reg) begin
                long_act_reg <= 1'b0;
            end
        end
    end

    // Running sums over the open windows.
    always_ff @(posedge aclk) begin
        if (ctl.start) begin
            short_sum_reg <= '0;
            long_sum_reg  <= '0;
        end else if (ctl.entry_vld) begin
            if (short_act_reg && (ent_time >= short_cut_reg)) begin
                short_sum_reg <= short_sum_reg + dur_ext;
            end
            if (long_act_reg && (ent_time >= long_cut_reg)) begin
                long_sum_reg <= long_sum_reg + dur_ext;
            end
        end
    end

    // Shared multiplier: short sum first, long sum (pre-divided by 8) next.
    assign mul_a = ctl.mul_long ? MUL_W'(long_sum_reg[DUR_W-1:3])
                                : MUL_W'(short_sum_reg[15:0]);
    assign mul_b = ctl.mul_long ? LONG_RECIP : SHORT_RECIP;

    always_ff @(posedge aclk) begin
        if (ctl.mul_short || ctl.mul_long) begin
            prod_reg <= mul_a * mul_b;
        end
    end

    // Short result is captured while the long product is formed.
    always_ff @(posedge aclk) begin
        if (ctl.mul_long) begin
            short_cpct_reg <= (short_sum_reg >= SHORT_WIN_MS) ? FULL_CPCT
                                : prod_reg[SHORT_SHIFT +: CPCT_W];
        end
    end

    assign long_act   = long_act_reg;
    assign short_cpct = short_cpct_reg;
    assign long_cpct  = (long_sum_reg >= LONG_WIN_MS) ? FULL_CPCT
                            : prod_reg[LONG_SHIFT +: CPCT_W];

endmodule

@@ hdl/airtime_duty_cycle_limiter_unit.sv @@
// A record beat stores its time and duration in the ring of the last SLOTS
// transmissions, overwriting the oldest. A query beat walks the ring newest
// to oldest, one RAM read per cycle. It stops reading one entry after the
// first entry older than the long window, or when the valid entries run out.
// The input is ready again once the walk, the short and long multiplications
// and the result load are done; the result load waits while the previous
// result still waits in the output register. Each query returns one result
// beat with both usages and the blocked flag; records return nothing. A
// finished result waits in the output register while the next beat is
// accepted.
// ----------------------------------------------------------------------------
// Airtime duty-cycle limiter
// Sliding-window airtime accounting over 60 s and 3600 s with limit check.
// ----------------------------------------------------------------------------
module airtime_duty_cycle_limiter_unit #(
    parameter int SLOTS = 64
) (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              cfg_wr_en,
    input  logic [adcl_pkg::CFG_ADDR_W-1:0]   cfg_addr,
    input  logic [adcl_pkg::CPCT_W-1:0]       cfg_wdata,
    input  logic                              s_valid,
    output logic                              s_ready,
    input  logic                              s_req_type,
    input  logic [adcl_pkg::TIME_W-1:0]       s_time_us,
    input  logic [adcl_pkg::DUR_W-1:0]        s_airtime_ms,
    output logic                              m_valid,
    input  logic                              m_ready,
    output logic [adcl_pkg::CPCT_W-1:0]       m_short_usage_cpct,
    output logic [adcl_pkg::CPCT_W-1:0]       m_long_usage_cpct,
    output logic                              m_blocked
);

    import adcl_pkg::*;

    localparam int IDX_W = (SLOTS > 1) ? $clog2(SLOTS) : 1;

    logic [CPCT_W-1:0]  short_limit_reg;
    logic [CPCT_W-1:0]  long_limit_reg;
    logic               m_valid_reg;
    logic [CPCT_W-1:0]  short_out_reg;
    logic [CPCT_W-1:0]  long_out_reg;
    logic               blocked_reg;
    adcl_ctl_t          ctl;
    logic               wr_en;
    logic [IDX_W-1:0]   wr_addr;
    logic               rd_en;
    logic [IDX_W-1:0]   rd_addr;
    logic [ENTRY_W-1:0] wr_data;
    logic [ENTRY_W-1:0] rd_data;
    logic               out_load;
    logic               out_free;
    logic               long_act;
    logic [DUR_W-1:0]   dur_sat;
    logic [CPCT_W-1:0]  short_cpct;
    logic [CPCT_W-1:0]  long_cpct;
    logic               blocked;

    // Limit registers.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            short_limit_reg <= '0;
            long_limit_reg  <= '0;
        end else if (cfg_wr_en) begin
            case (cfg_addr)
                CFG_SHORT_LIMIT: short_limit_reg <= cfg_wdata;
                CFG_LONG_LIMIT:  long_limit_reg  <= cfg_wdata;
                default: begin
                end
            endcase
        end
    end

    // Record entry: duration saturates at one hour.
    assign dur_sat = (s_airtime_ms > MAX_DUR_MS) ? MAX_DUR_MS : s_airtime_ms;
    assign wr_data = {s_time_us, dur_sat};

    assign out_free = !m_valid_reg || m_ready;

    adcl_seq #(
        .SLOTS(SLOTS)
    ) u_seq (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_req_type(s_req_type),
        .s_ready   (s_ready),
        .out_free  (out_free),
        .long_act  (long_act),
        .ctl       (ctl),
        .wr_en     (wr_en),
        .wr_addr   (wr_addr),
        .rd_en     (rd_en),
        .rd_addr   (rd_addr),
        .out_load  (out_load)
    );

    adcl_ram #(
        .WIDTH(ENTRY_W),
        .DEPTH(SLOTS)
    ) u_ring (
        .aclk   (aclk),
        .wr_en  (wr_en),
        .wr_addr(wr_addr),
        .wr_data(wr_data),
        .rd_en  (rd_en),
        .rd_addr(rd_addr),
        .rd_data(rd_data)
    );

    adcl_datapath u_dp (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .ctl       (ctl),
        .now_us    (s_time_us),
        .ent_time  (rd_data[ENTRY_W-1:DUR_W]),
        .ent_dur   (rd_data[DUR_W-1:0]),
        .long_act  (long_act),
        .short_cpct(short_cpct),
        .long_cpct (long_cpct)
    );

    // Limit check: a zero limit is disabled.
    assign blocked = ((short_limit_reg != '0) && (short_cpct >= short_limit_reg)) ||
                     ((long_limit_reg != '0) && (long_cpct >= long_limit_reg));

    // Output register.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (out_load) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (out_load) begin
            short_out_reg <= short_cpct;
            long_out_reg  <= long_cpct;
            blocked_reg   <= blocked;
        end
    end

    assign m_valid            = m_valid_reg;
    assign m_short_usage_cpct = short_out_reg;
    assign m_long_usage_cpct  = long_out_reg;
    assign m_blocked          = blocked_reg;

    // Usages never exceed full scale.
    a_cpct_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (m_short_usage_cpct <= FULL_CPCT) && (m_long_usage_cpct <= FULL_CPCT))
        else $error("usage beyond full scale");

    // Blocked needs at least one enabled limit.
    a_blocked_enabled: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_blocked) |-> (short_limit_reg != '0) || (long_limit_reg != '0))
        else $error("blocked with both limits disabled");

    // A record beat on an empty output never raises a result.
    a_record_silent: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready && (s_req_type == REQ_RECORD) && !m_valid) |=> !m_valid)
        else $error("result after record beat");

    // The ring is never written while a query is in progress.
    a_no_write_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        wr_en |-> s_ready)
        else $error("ring write outside idle");

endmodule
